@@ hw/rtl/btl_pkg.sv @@
`default_nettype none

package btl_pkg;

  // Tape byte codes
  localparam logic [7:0] RUBOUT  = 8'o377;
  localparam logic [7:0] TRAILER = 8'o200;
  localparam logic [7:0] BLANK   = 8'o000;

  // Field excuses: dest 2 quietly drops field 0, dest 3 accepts field 4
  localparam logic [2:0] DROP_DEST   = 3'd2;
  localparam logic [2:0] DROP_FIELD  = 3'd0;
  localparam logic [2:0] ALIAS_DEST  = 3'd3;
  localparam logic [2:0] ALIAS_FIELD = 3'd4;

  // Parser phase, one-hot
  typedef enum logic [2:0] {
    PH_LEADER = 3'b001,  // leader or waiting for a high frame
    PH_LOW    = 3'b010,  // high frame held, waiting for the low frame
    PH_WORD   = 3'b100   // both frames held, next byte completes the word
  } phase_t;

  typedef enum logic {
    RES_WRITE = 1'b0,
    RES_END   = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  write_field;
    logic [11:0] write_address;
    logic [11:0] write_data;
    logic        write_allowed;
    logic        field_error;
    logic        checksum_ok;
    logic        any_error;
  } res_t;

endpackage

`default_nettype wire

@@ hw/rtl/btl_if.sv @@
`default_nettype none

// Tape byte channel
interface btl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] tape_byte;
  logic       new_tape;

  modport source (output valid, tape_byte, new_tape, input ready);
  modport sink   (input valid, tape_byte, new_tape, output ready);
endinterface

// Memory write / end-of-tape channel
interface btl_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [2:0]  write_field;
  logic [11:0] write_address;
  logic [11:0] write_data;
  logic        write_allowed;
  logic        field_error;
  logic        checksum_ok;
  logic        any_error;

  modport source (output valid, result_kind, write_field, write_address, write_data,
                  write_allowed, field_error, checksum_ok, any_error, input ready);
  modport sink   (input valid, result_kind, write_field, write_address, write_data,
                  write_allowed, field_error, checksum_ok, any_error, output ready);
endinterface

// Destination field register write channel
interface btl_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] dest_field;

  modport source (output valid, dest_field, input ready);
  modport sink   (input valid, dest_field, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/btl_core.sv @@
`default_nettype none

module btl_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          item_go,
  input  logic [7:0]    tape_byte,
  input  logic          new_tape,
  input  logic [2:0]    dest_field,
  output logic          res_valid,
  output btl_pkg::res_t res
);
  import btl_pkg::*;

  phase_t      phase_r, phase_nxt, s_phase;
  logic        skip_r, skip_nxt, s_skip;
  logic [7:0]  high_r, high_nxt, s_high;
  logic [7:0]  low_r, low_nxt, s_low;
  logic [11:0] sum_r, sum_nxt, s_sum;
  logic [11:0] origin_r, origin_nxt, s_origin;
  logic [2:0]  active_r, active_nxt, s_active;
  logic        fvalid_r, fvalid_nxt, s_fvalid;
  logic [2:0]  pending_r, pending_nxt, s_pending;
  logic        finished_r, finished_nxt, s_finished;
  logic        err_r, err_nxt, s_err;

  logic [13:0] word;
  logic        is_origin;
  logic        sum_ok;
  logic        drop;
  logic        excuse;
  logic        word_err;
  logic [11:0] frame_sum;

  // Start of tape: state seen by this byte is the fresh-tape state
  assign s_phase    = new_tape ? PH_LEADER  : phase_r;
  assign s_skip     = new_tape ? 1'b0       : skip_r;
  assign s_high     = new_tape ? BLANK      : high_r;
  assign s_low      = new_tape ? BLANK      : low_r;
  assign s_sum      = new_tape ? 12'd0      : sum_r;
  assign s_origin   = new_tape ? 12'd0      : origin_r;
  assign s_active   = new_tape ? 3'd0       : active_r;
  assign s_fvalid   = new_tape ? 1'b0       : fvalid_r;
  assign s_pending  = new_tape ? dest_field : pending_r;
  assign s_finished = new_tape ? 1'b0       : finished_r;
  assign s_err      = new_tape ? 1'b0       : err_r;

  // Word assembly; frames are combined unmasked so a 0200 frame reaches the origin bits
  assign word      = {s_high, 6'd0} | {6'd0, s_low};
  assign is_origin = |word[13:12];
  assign sum_ok    = (s_sum == word[11:0]);
  assign frame_sum = s_sum + {4'd0, s_low} + {4'd0, s_high};

  // Field checks against the current destination
  assign drop     = (dest_field == DROP_DEST) && (s_active == DROP_FIELD);
  assign excuse   = drop || ((dest_field == ALIAS_DEST) && (s_active == ALIAS_FIELD));
  assign word_err = !s_fvalid || ((s_active != dest_field) && !excuse);

  // Per-byte parse step
  always_comb begin
    phase_nxt    = s_phase;
    skip_nxt     = s_skip;
    high_nxt     = s_high;
    low_nxt      = s_low;
    sum_nxt      = s_sum;
    origin_nxt   = s_origin;
    active_nxt   = s_active;
    fvalid_nxt   = s_fvalid;
    pending_nxt  = s_pending;
    finished_nxt = s_finished;
    err_nxt      = s_err;
    res_valid    = 1'b0;
    res          = '0;

    if (s_finished) begin
      // tape ended: swallow everything
    end else if (s_skip) begin
      skip_nxt = 1'b0;
    end else if (tape_byte == RUBOUT) begin
      skip_nxt = 1'b1;
    end else if (tape_byte > TRAILER) begin
      pending_nxt = tape_byte[5:3];
    end else begin
      case (s_phase)
        PH_LOW: begin
          low_nxt   = tape_byte;
          phase_nxt = PH_WORD;
        end
        PH_WORD: begin
          if (tape_byte == TRAILER) begin
            finished_nxt    = 1'b1;
            err_nxt         = s_err || !sum_ok;
            res_valid       = 1'b1;
            res.kind        = RES_END;
            res.checksum_ok = sum_ok;
            res.any_error   = s_err || !sum_ok;
          end else begin
            sum_nxt = frame_sum;
            if (is_origin) begin
              origin_nxt = word[11:0];
            end else begin
              res_valid         = 1'b1;
              res.kind          = RES_WRITE;
              res.write_field   = s_fvalid ? s_active : 3'd0;
              res.write_address = s_origin;
              res.write_data    = word[11:0];
              res.write_allowed = s_fvalid && !drop;
              res.field_error   = word_err;
              err_nxt           = s_err || word_err;
              origin_nxt        = s_origin + 12'd1;
            end
            active_nxt = s_pending;
            fvalid_nxt = 1'b1;
            high_nxt   = tape_byte;
            phase_nxt  = PH_LOW;
          end
        end
        default: begin
          if (!(tape_byte inside {BLANK, TRAILER})) begin
            phase_nxt = PH_LOW;
          end
          high_nxt = tape_byte;
        end
      endcase
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_LEADER;
      skip_r     <= 1'b0;
      high_r     <= '0;
      low_r      <= '0;
      sum_r      <= '0;
      origin_r   <= '0;
      active_r   <= '0;
      fvalid_r   <= 1'b0;
      pending_r  <= '0;
      finished_r <= 1'b0;
      err_r      <= 1'b0;
    end else if (item_go) begin
      phase_r    <= phase_nxt;
      skip_r     <= skip_nxt;
      high_r     <= high_nxt;
      low_r      <= low_nxt;
      sum_r      <= sum_nxt;
      origin_r   <= origin_nxt;
      active_r   <= active_nxt;
      fvalid_r   <= fvalid_nxt;
      pending_r  <= pending_nxt;
      finished_r <= finished_nxt;
      err_r      <= err_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/binary_tape_loader_parser_top.sv @@
`default_nettype none

// Binary paper-tape loader parser. Takes one tape byte per cycle on in_ch and
// emits at most one word on out_ch per byte: a memory write (field, address,
// data, store and error flags) or an end-of-tape word carrying the checksum
// verdict. A byte waits in the input register until it advances; the parser
// state updates as it leaves, and any result lands in the output register at
// that same edge. Throughput is one byte per cycle, paced only by out_ch.ready
// when the output register is full.
// Assert new_tape with the first byte of each tape. dest_field is written over
// cfg_ch and should only be changed while no bytes are in flight.
module binary_tape_loader_parser_top (
  input  logic      clk,
  input  logic      rst_n,
  btl_in_if.sink    in_ch,
  btl_out_if.source out_ch,
  btl_cfg_if.sink   cfg_ch
);
  import btl_pkg::*;

  logic       cfg_wr;
  logic [2:0] dest_field_r;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_new_r;
  logic       advance;

  logic       res_valid;
  res_t       res;
  logic       out_valid_r;
  res_t       out_res_r;

  // Destination field register
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_field_r <= '0;
    end else if (cfg_wr) begin
      dest_field_r <= cfg_ch.dest_field;
    end
  end

  // Input register
  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.tape_byte;
      s1_new_r  <= in_ch.new_tape;
    end
  end

  btl_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_go    (advance),
    .tape_byte  (s1_byte_r),
    .new_tape   (s1_new_r),
    .dest_field (dest_field_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.result_kind   = out_res_r.kind;
  assign out_ch.write_field   = out_res_r.write_field;
  assign out_ch.write_address = out_res_r.write_address;
  assign out_ch.write_data    = out_res_r.write_data;
  assign out_ch.write_allowed = out_res_r.write_allowed;
  assign out_ch.field_error   = out_res_r.field_error;
  assign out_ch.checksum_ok   = out_res_r.checksum_ok;
  assign out_ch.any_error     = out_res_r.any_error;

  // A held byte is neither dropped nor altered while the output is stalled
  a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_byte_r) && $stable(s1_new_r))
    else $error("input byte lost while stalled");

  // A bad checksum always shows in the error summary
  a_sum_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.kind == RES_END) && !out_res_r.checksum_ok
      |-> out_res_r.any_error)
    else $error("checksum failure not reported as error");

  // End words carry no write
  a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.kind == RES_END)
      |-> !out_res_r.write_allowed && !out_res_r.field_error)
    else $error("end word carries write flags");

  // A stored word is only flagged when its field differs from the destination
  a_unset: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res_valid && (res.kind == RES_WRITE) && res.write_allowed
      |-> !res.field_error || (res.write_field != dest_field_r))
    else $error("stored word flagged without field mismatch");

endmodule

`default_nettype wire

@@ dv/binary_tape_loader_parser_top_test.sv @@
module binary_tape_loader_parser_top_test;
  import btl_pkg::*;

  localparam int          QUIET_LIMIT = 1000;
  localparam logic [13:0] ORIGIN_FLAG = 14'o10000;
  localparam int          N_OPENING   = 22;
  // Opening tape bytes, new_tape in bit 8, first byte in the top slice
  localparam logic [N_OPENING*9-1:0] OPENING = {
    9'o400, 9'o200, 9'o377, 9'o102, 9'o001, 9'o200, 9'o376, 9'o101,
    9'o200, 9'o201, 9'o077, 9'o077, 9'o000, 9'o000, 9'o077, 9'o000,
    9'o200, 9'o001, 9'o377, 9'o777, 9'o377, 9'o600};
  // Destination field for each random phase, first phase in the top slice
  localparam logic [23:0] DEST_PLAN = {3'd7, 3'd2, 3'd3, 3'd0, 3'd5, 3'd3, 3'd2, 3'd6};

  typedef enum logic [1:0] {PACE_FULL, PACE_SRC_IDLE, PACE_SNK_STALL, PACE_BOTH} pace_t;

  typedef struct {
    logic [7:0] tape_byte;
    logic       new_tape;
    bit         drain_first;  // hold this byte back until every word has come out
  } tape_item_t;

  logic clk;
  logic rst_n;

  btl_in_if  in_ch ();
  btl_out_if out_ch ();
  btl_cfg_if cfg_ch ();

  binary_tape_loader_parser_top DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Stimulus bookkeeping
  tape_item_t  tape_q[$];
  res_t        words_due[$];
  pace_t       pace;
  int          queued_bytes;
  int          bytes_taken;
  int          failures;
  int          quiet_cycles;
  bit          byte_taken;
  bit          cfg_taken;
  logic [11:0] gen_sum;
  logic [2:0]  dest_now;

  // Parser copy used for prediction
  logic [2:0]  dest_field_q;
  phase_t      tape_phase;
  bit          skip_byte;
  logic [7:0]  hi_fr;
  logic [7:0]  lo_fr;
  logic [11:0] csum;
  logic [11:0] origin;
  logic [2:0]  cur_field;
  logic [2:0]  next_field;
  bit          field_set;
  bit          tape_done;
  bit          tape_err;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void rewind_parser();
    tape_phase = PH_LEADER;
    skip_byte  = 1'b0;
    hi_fr      = '0;
    lo_fr      = '0;
    csum       = '0;
    origin     = '0;
    cur_field  = '0;
    field_set  = 1'b0;
    next_field = dest_field_q;
    tape_done  = 1'b0;
    tape_err   = 1'b0;
  endfunction

  // Work out the word (if any) that one accepted tape byte produces
  function automatic void parse_tape_byte(input logic [7:0] b, input logic nt);
    logic [13:0] word;
    res_t        r;
    bit          ok;
    bit          allow;
    bit          excuse;
    bit          err;
    if (nt) rewind_parser();
    if (tape_done) return;
    if (skip_byte) begin
      skip_byte = 1'b0;
      return;
    end
    if (b == RUBOUT) begin
      skip_byte = 1'b1;
      return;
    end
    if (b > TRAILER) begin
      next_field = b[5:3];
      return;
    end
    if (tape_phase == PH_LOW) begin
      lo_fr      = b;
      tape_phase = PH_WORD;
      return;
    end
    if (tape_phase != PH_WORD) begin
      if (b != BLANK && b != TRAILER) tape_phase = PH_LOW;
      hi_fr = b;
      return;
    end
    // Third byte completes the word; frames are combined unmasked
    word = {hi_fr, 6'b0} | 14'(lo_fr);
    r    = '0;
    if (b == TRAILER) begin
      ok = (csum == word[11:0]);
      if (!ok) tape_err = 1'b1;
      tape_done     = 1'b1;
      r.kind        = RES_END;
      r.checksum_ok = ok;
      r.any_error   = tape_err;
      words_due.push_back(r);
      return;
    end
    csum = csum + hi_fr + lo_fr;
    if (word >= ORIGIN_FLAG) begin
      origin = word[11:0];
    end else begin
      allow  = 1'b1;
      excuse = 1'b0;
      err    = 1'b0;
      if (!field_set) begin
        allow = 1'b0;
        err   = 1'b1;
      end else begin
        if (dest_field_q == DROP_DEST && cur_field == DROP_FIELD) begin
          excuse = 1'b1;
          allow  = 1'b0;
        end
        if (dest_field_q == ALIAS_DEST && cur_field == ALIAS_FIELD) excuse = 1'b1;
        if (cur_field != dest_field_q && !excuse) err = 1'b1;
      end
      if (err) tape_err = 1'b1;
      r.kind          = RES_WRITE;
      r.write_field   = field_set ? cur_field : 3'd0;
      r.write_address = origin;
      r.write_data    = word[11:0];
      r.write_allowed = allow;
      r.field_error   = err;
      words_due.push_back(r);
      origin = origin + 12'd1;
    end
    cur_field  = next_field;
    field_set  = 1'b1;
    hi_fr      = b;
    tape_phase = PH_LOW;
  endfunction

  task automatic compare_field(input string name, input logic [11:0] want_v,
                               input logic [11:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0o, got %0o", $time, name, want_v, got_v);
      failures++;
    end
  endtask

  task automatic check_word_out();
    res_t want;
    if (words_due.size() == 0) begin
      $display("%0t: unexpected word, kind %0d field %0o addr %0o data %0o", $time,
               out_ch.result_kind, out_ch.write_field, out_ch.write_address,
               out_ch.write_data);
      failures++;
    end else begin
      want = words_due.pop_front();
      compare_field("result_kind",   12'(want.kind),          12'(out_ch.result_kind));
      compare_field("write_field",   12'(want.write_field),   12'(out_ch.write_field));
      compare_field("write_address", want.write_address,      out_ch.write_address);
      compare_field("write_data",    want.write_data,         out_ch.write_data);
      compare_field("write_allowed", 12'(want.write_allowed), 12'(out_ch.write_allowed));
      compare_field("field_error",   12'(want.field_error),   12'(out_ch.field_error));
      compare_field("checksum_ok",   12'(want.checksum_ok),   12'(out_ch.checksum_ok));
      compare_field("any_error",     12'(want.any_error),     12'(out_ch.any_error));
    end
  endtask

  // Monitor: predict on accepted bytes, check accepted words, track quiet cycles
  always @(posedge clk) begin
    if (!rst_n) begin
      byte_taken   <= 1'b0;
      cfg_taken    <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      byte_taken <= in_ch.valid && in_ch.ready;
      cfg_taken  <= cfg_ch.valid && cfg_ch.ready;
      if (out_ch.valid && out_ch.ready) check_word_out();
      if (cfg_ch.valid && cfg_ch.ready) dest_field_q = cfg_ch.dest_field;
      if (in_ch.valid && in_ch.ready) begin
        parse_tape_byte(in_ch.tape_byte, in_ch.new_tape);
        bytes_taken++;
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic bit sender_idles();
    case (pace)
      PACE_SRC_IDLE: return $urandom_range(0, 99) < 75;
      PACE_BOTH:     return $urandom_range(0, 99) < 6;
      default:       return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (pace)
      PACE_SNK_STALL: return $urandom_range(0, 99) < 75;
      PACE_BOTH:      return $urandom_range(0, 99) < 6;
      default:        return 1'b0;
    endcase
  endfunction

  // Driver: present the next queued byte once the current one is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.tape_byte <= '0;
      in_ch.new_tape  <= 1'b0;
    end else if (!in_ch.valid || byte_taken) begin
      if (tape_q.size() != 0 && !(tape_q[0].drain_first && words_due.size() != 0) &&
          !sender_idles()) begin
        in_ch.valid     <= 1'b1;
        in_ch.tape_byte <= tape_q[0].tape_byte;
        in_ch.new_tape  <= tape_q[0].new_tape;
        void'(tape_q.pop_front());
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !receiver_stalls();
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic nt);
    tape_item_t item;
    item.tape_byte   = b;
    item.new_tape    = nt;
    item.drain_first = ($urandom_range(0, 199) == 0);
    tape_q.push_back(item);
    queued_bytes++;
  endtask

  task automatic push_frames(input logic [7:0] hi, input logic [7:0] lo);
    push_byte(hi, 1'b0);
    push_byte(lo, 1'b0);
    gen_sum = gen_sum + hi + lo;
  endtask

  // Field select byte: above 0200, field in bits 5:3, never rubout or trailer
  function automatic logic [7:0] field_byte(input logic [2:0] f);
    logic [7:0] b;
    b = {1'b1, 1'($urandom_range(0, 1)), f, 3'($urandom_range(0, 7))};
    if (b == TRAILER || b == RUBOUT) b = {2'b11, f, 3'b110};
    return b;
  endfunction

  // Mostly the destination, often the two excused fields, sometimes anything
  function automatic logic [2:0] pick_field();
    case ($urandom_range(0, 5))
      0, 1, 2: return dest_now;
      3:       return DROP_FIELD;
      4:       return ALIAS_FIELD;
      default: return 3'($urandom_range(0, 7));
    endcase
  endfunction

  task automatic open_tape();
    int          n_lead;
    logic [11:0] org;
    n_lead  = $urandom_range(1, 4);
    gen_sum = '0;
    for (int i = 0; i < n_lead; i++)
      push_byte($urandom_range(0, 1) ? TRAILER : BLANK, i == 0);
    if ($urandom_range(0, 7) != 0) push_byte(field_byte(pick_field()), 1'b0);
    if ($urandom_range(0, 7) != 0) begin
      // origin near the top now and then so the address wraps
      if ($urandom_range(0, 3) == 0) org = 12'o7770 + 12'($urandom_range(0, 7));
      else org = 12'($urandom);
      push_frames({2'b01, org[11:6]}, {2'b00, org[5:0]});
    end else begin
      // data before any word: high frame kept nonzero so it is not leader
      org = 12'($urandom_range(64, 4095));
      push_frames({2'b00, org[11:6]}, {2'b00, org[5:0]});
    end
  endtask

  task automatic data_words(input int n);
    logic [11:0] w;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0: push_byte(field_byte(pick_field()), 1'b0);
        1: begin
          push_byte(RUBOUT, 1'b0);
          push_byte(8'($urandom), 1'b0);
        end
        2: begin
          w = 12'($urandom);
          push_frames({2'b01, w[11:6]}, {2'b00, w[5:0]});
        end
        default: ;
      endcase
      w = 12'($urandom);
      push_frames({2'b00, w[11:6]}, {2'b00, w[5:0]});
    end
  endtask

  task automatic close_tape();
    logic [11:0] s;
    s = gen_sum;
    if ($urandom_range(0, 5) == 0) s = s ^ 12'($urandom_range(1, 4095));
    push_byte({2'b00, s[11:6]}, 1'b0);
    push_byte({2'b00, s[5:0]}, 1'b0);
    push_byte(TRAILER, 1'b0);
    // junk after the trailer must be ignored
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0);
  endtask

  task automatic noise_tape();
    repeat ($urandom_range(8, 30)) push_byte(8'($urandom), $urandom_range(0, 15) == 0);
  endtask

  // Idle: every byte taken, every word out, then the pipeline latency
  task automatic wait_idle();
    do @(negedge clk);
    while (bytes_taken != queued_bytes || words_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_dest(input logic [2:0] v);
    @(negedge clk);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.dest_field <= v;
    do @(negedge clk);
    while (!cfg_taken);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin : stimulus
    int   phase_end;
    bit   tape_open;
    logic [8:0] op;
    rst_n             = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.dest_field = '0;
    pace              = PACE_FULL;
    dest_now          = '0;
    dest_field_q      = '0;
    queued_bytes      = 0;
    bytes_taken       = 0;
    failures          = 0;
    gen_sum           = '0;
    tape_open         = 1'b0;
    rewind_parser();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed opening: leader, rubouts, unset field, trailer-valued frames,
    // words after the end, and one byte held until the output drains
    for (int i = 0; i < N_OPENING; i++) begin
      op = OPENING[(N_OPENING - 1 - i) * 9 +: 9];
      push_byte(op[7:0], op[8]);
      tape_q[tape_q.size() - 1].drain_first = (i == 19);
    end

    // Random phases, each with its own destination field and pacing
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      dest_now = DEST_PLAN[(7 - p) * 3 +: 3];
      set_dest(dest_now);
      pace = pace_t'(p % 4);
      // finish a tape left open across the register change
      if (tape_open) begin
        data_words($urandom_range(1, 6));
        close_tape();
      end
      phase_end = queued_bytes + 190;
      while (queued_bytes < phase_end) begin
        if ($urandom_range(0, 5) == 0) begin
          noise_tape();
        end else begin
          open_tape();
          data_words($urandom_range(0, 24));
          close_tape();
        end
      end
      tape_open = (p % 2 == 0);
      if (tape_open) begin
        open_tape();
        data_words($urandom_range(1, 4));
      end
    end

    wait_idle();
    repeat (6) @(negedge clk);
    if (failures == 0 && words_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog on cycles with no traffic on any channel
  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t: no traffic for %0d cycles, %0d words outstanding", $time,
             QUIET_LIMIT, words_due.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/btl_pkg.sv
hw/rtl/btl_if.sv
hw/rtl/btl_core.sv
hw/rtl/binary_tape_loader_parser_top.sv
dv/binary_tape_loader_parser_top_test.sv
